>>> hdl/mauco_pkg.sv
// Shared constants for the modular arithmetic unit over the secp256k1 group order.
// Holds the opcode codes, the order and its half, and the digit width of the serial datapath.
// No dependencies.
package mauco_pkg;

  localparam int unsigned WIDTH = 256;
  localparam int unsigned DIGIT = 64;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_INV  = 3'd3,
    FN_LOWS = 3'd4
  } func_t;

  localparam logic [WIDTH-1:0] ORDER_N =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
  localparam logic [WIDTH-1:0] ORDER_HALF =
    256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

endpackage

>>> hdl/modular_arith_unit_curve_order.sv
// Modular add, subtract, multiply, inverse and low-s fold modulo the secp256k1 order.
// Four 256-bit shift registers rotate one 64-bit digit per cycle through one add/sub unit.
// Depends on mauco_pkg.
//
//   channel | handshake           | payload
//   in      | in_valid, in_stall  | func, operand_a_word0..3, operand_b_word0..3
//   out     | out_valid, out_stall| result_word0..3
//
// Every 256-bit pass works one 64-bit digit at a time through the shared adder.
// Add, subtract, low-s: a single pass. Multiply: 256 Horner steps of one or two passes.
// Inverse: one pass per halving and two per subtract step. Unused opcodes give zero.
// Synchronous reset clears the controller; in_stall is high while an item is in work,
// and a finished result waits in the output register while out_stall is high.
module modular_arith_unit_curve_order (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   func,
  input  logic [63:0]  operand_a_word0,
  input  logic [63:0]  operand_a_word1,
  input  logic [63:0]  operand_a_word2,
  input  logic [63:0]  operand_a_word3,
  input  logic [63:0]  operand_b_word0,
  input  logic [63:0]  operand_b_word1,
  input  logic [63:0]  operand_b_word2,
  input  logic [63:0]  operand_b_word3,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [63:0]  result_word0,
  output logic [63:0]  result_word1,
  output logic [63:0]  result_word2,
  output logic [63:0]  result_word3
);

  localparam int unsigned W = mauco_pkg::WIDTH;
  localparam int unsigned D = mauco_pkg::DIGIT;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_MUL_LOOP, S_MUL_BIT, S_INV_LOOP, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    P_ADD, P_SUB, P_LOWS, P_RED, P_DBL, P_ACC, P_HALFA, P_HALFC, P_CMP, P_UPD
  } pass_t;

  state_t       state;
  pass_t        pass;
  logic [2:0]   fn;
  logic [W-1:0] ra, rb, rc, rd, tp, tq, res;
  logic [1:0]   k;
  logic         c1, c2, odd, sw, bit_q;
  logic [8:0]   cnt;

  logic [D-1:0] x, y, nd, hd, pdig, qdig;
  logic [D:0]   s, q;
  logic [W-1:0] pf, qf, rot_a, rot_b, rot_c, rot_d;
  logic         c1o, c2o;

  assign nd = mauco_pkg::ORDER_N[k*D +: D];
  assign hd = mauco_pkg::ORDER_HALF[k*D +: D];

  always_comb begin
    x = ra[D-1:0];
    y = rb[D-1:0];
    case (pass)
      P_DBL:   begin x = rc[D-1:0]; y = rc[D-1:0]; end
      P_ACC:   begin x = rc[D-1:0]; y = ra[D-1:0]; end
      P_HALFA: begin x = rc[D-1:0]; y = odd ? nd : '0; end
      P_HALFC: begin x = rd[D-1:0]; y = odd ? nd : '0; end
      P_UPD:   begin
        x = sw ? rd[D-1:0] : rc[D-1:0];
        y = sw ? rc[D-1:0] : rd[D-1:0];
      end
      default: ;
    endcase
    s = '0;
    q = '0;
    pdig = '0;
    qdig = '0;
    case (pass)
      P_ADD, P_DBL, P_ACC: begin
        s = {1'b0, x} + {1'b0, y} + (D+1)'(c1);
        q = {1'b0, s[D-1:0]} - {1'b0, nd} - (D+1)'(c2);
        pdig = s[D-1:0];
        qdig = q[D-1:0];
      end
      P_SUB, P_UPD: begin
        s = {1'b0, x} - {1'b0, y} - (D+1)'(c1);
        q = {1'b0, s[D-1:0]} + {1'b0, nd} + (D+1)'(c2);
        pdig = s[D-1:0];
        qdig = q[D-1:0];
      end
      P_LOWS: begin
        s = {1'b0, hd} - {1'b0, x} - (D+1)'(c1);
        q = {1'b0, nd} - {1'b0, x} - (D+1)'(c2);
        pdig = x;
        qdig = q[D-1:0];
      end
      P_RED: begin
        q = {1'b0, x} - {1'b0, nd} - (D+1)'(c2);
        pdig = x;
        qdig = q[D-1:0];
      end
      P_HALFA, P_HALFC: begin
        s = {1'b0, x} + {1'b0, y} + (D+1)'(c1);
        pdig = s[D-1:0];
      end
      P_CMP: begin
        s = {1'b0, x} - {1'b0, y} - (D+1)'(c1);
        q = {1'b0, y} - {1'b0, x} - (D+1)'(c2);
        pdig = s[D-1:0];
        qdig = q[D-1:0];
      end
      default: ;
    endcase
  end

  assign c1o   = s[D];
  assign c2o   = q[D];
  assign pf    = {pdig, tp[W-1:D]};
  assign qf    = {qdig, tq[W-1:D]};
  assign rot_a = {ra[D-1:0], ra[W-1:D]};
  assign rot_b = {rb[D-1:0], rb[W-1:D]};
  assign rot_c = {rc[D-1:0], rc[W-1:D]};
  assign rot_d = {rd[D-1:0], rd[W-1:D]};

  assign in_stall     = (state != S_IDLE);
  assign result_word0 = res[63:0];
  assign result_word1 = res[127:64];
  assign result_word2 = res[191:128];
  assign result_word3 = res[255:192];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      c1        <= 1'b0;
      c2        <= 1'b0;
      cnt       <= '0;
      pass      <= P_ADD;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fn  <= func;
            ra  <= {operand_a_word3, operand_a_word2, operand_a_word1, operand_a_word0};
            rb  <= (func == mauco_pkg::FN_INV) ? mauco_pkg::ORDER_N :
                   {operand_b_word3, operand_b_word2, operand_b_word1, operand_b_word0};
            rc  <= (func == mauco_pkg::FN_INV) ? W'(1) : '0;
            rd  <= '0;
            k   <= '0;
            c1  <= 1'b0;
            c2  <= 1'b0;
            cnt <= '0;
            case (func)
              mauco_pkg::FN_ADD:  begin pass <= P_ADD;  state <= S_PASS; end
              mauco_pkg::FN_SUB:  begin pass <= P_SUB;  state <= S_PASS; end
              mauco_pkg::FN_LOWS: begin pass <= P_LOWS; state <= S_PASS; end
              mauco_pkg::FN_MUL:  begin pass <= P_RED;  state <= S_PASS; end
              mauco_pkg::FN_INV:  state <= S_INV_LOOP;
              default:            state <= S_FIN;
            endcase
          end
        end
        S_PASS: begin
          tp <= pf;
          tq <= qf;
          k  <= k + 2'd1;
          if (k != 2'd3) begin
            ra <= rot_a;
            rb <= rot_b;
            rc <= rot_c;
            rd <= rot_d;
            c1 <= c1o;
            c2 <= c2o;
          end else begin
            c1 <= 1'b0;
            c2 <= 1'b0;
            unique case (pass)
              P_ADD, P_DBL, P_ACC: begin
                ra <= rot_a;
                rb <= rot_b;
                rd <= rot_d;
                rc <= (c1o || !c2o) ? qf : pf;
                state <= (pass == P_ADD) ? S_FIN :
                         (pass == P_DBL) ? S_MUL_BIT : S_MUL_LOOP;
              end
              P_SUB, P_LOWS: begin
                ra <= rot_a;
                rb <= rot_b;
                rd <= rot_d;
                rc <= c1o ? qf : pf;
                state <= S_FIN;
              end
              P_RED: begin
                rb <= rot_b;
                rc <= rot_c;
                rd <= rot_d;
                ra <= c2o ? pf : qf;
                state <= S_MUL_LOOP;
              end
              P_HALFA: begin
                ra <= rot_a;
                rb <= rot_b;
                rd <= rot_d;
                rc <= {c1o, pf[W-1:1]};
                state <= S_INV_LOOP;
              end
              P_HALFC: begin
                ra <= rot_a;
                rb <= rot_b;
                rc <= rot_c;
                rd <= {c1o, pf[W-1:1]};
                state <= S_INV_LOOP;
              end
              P_CMP: begin
                if (c1o) begin
                  rb <= qf;
                  ra <= rot_a;
                end else begin
                  ra <= pf;
                  rb <= rot_b;
                end
                rc <= rot_c;
                rd <= rot_d;
                sw <= c1o;
                pass <= P_UPD;
              end
              P_UPD: begin
                ra <= rot_a;
                rb <= rot_b;
                if (sw) begin
                  rd <= c1o ? qf : pf;
                  rc <= rot_c;
                end else begin
                  rc <= c1o ? qf : pf;
                  rd <= rot_d;
                end
                state <= S_INV_LOOP;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_MUL_LOOP: begin
          if (cnt[8]) begin
            state <= S_FIN;
          end else begin
            cnt   <= cnt + 9'd1;
            bit_q <= rb[W-1];
            rb    <= {rb[W-2:0], 1'b0};
            pass  <= P_DBL;
            state <= S_PASS;
          end
        end
        S_MUL_BIT: begin
          if (bit_q) begin
            pass  <= P_ACC;
            state <= S_PASS;
          end else begin
            state <= S_MUL_LOOP;
          end
        end
        S_INV_LOOP: begin
          if (ra == '0) begin
            state <= S_FIN;
          end else if (!ra[0]) begin
            ra    <= {1'b0, ra[W-1:1]};
            odd   <= rc[0];
            pass  <= P_HALFA;
            state <= S_PASS;
          end else if (!rb[0]) begin
            rb    <= {1'b0, rb[W-1:1]};
            odd   <= rd[0];
            pass  <= P_HALFC;
            state <= S_PASS;
          end else begin
            pass  <= P_CMP;
            state <= S_PASS;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            case (fn)
              mauco_pkg::FN_ADD, mauco_pkg::FN_SUB,
              mauco_pkg::FN_MUL, mauco_pkg::FN_LOWS: res <= rc;
              mauco_pkg::FN_INV:                     res <= rd;
              default:                               res <= '0;
            endcase
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
